// ----- sv/cxcds_pkg.sv -----
// cxcds_pkg: widths, gain register indexes, reset gains and the sample
// sign-extension helper for the crosstalk-corrected cds block
// no dependencies
`default_nettype none

package cxcds_pkg;

    // sample path
    localparam int SAMPLE_BITS = 32;               // used low bits of each input field
    localparam int IN_W        = 32;               // input field port width
    localparam int DIFF_W      = SAMPLE_BITS + 1;  // difference of two samples

    // gains, unsigned q1.16
    localparam int GAIN_W    = 17;
    localparam int FRAC_IN   = 16;
    localparam int NUM_GAINS = 8;
    localparam int GIDX_W    = $clog2(NUM_GAINS);

    // accumulation and rounding
    localparam int PROD_W      = DIFF_W + GAIN_W + 1;
    localparam int ACC_W       = DIFF_W + FRAC_IN + 3;
    localparam int ROUND_SHIFT = 8;
    localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);
    localparam int Q8_W        = ACC_W - ROUND_SHIFT;

    // result widths
    localparam int CORR_W  = 44;
    localparam int PLAIN_W = 33;

    typedef enum logic [GIDX_W-1:0] {
        GAIN_A_FROM_C,
        GAIN_A_FROM_D,
        GAIN_B_FROM_C,
        GAIN_B_FROM_D,
        GAIN_C_FROM_A,
        GAIN_C_FROM_B,
        GAIN_D_FROM_A,
        GAIN_D_FROM_B
    } gain_idx_t;

    // highest index first
    localparam logic [NUM_GAINS-1:0][GAIN_W-1:0] GAIN_RESET = {
        17'd17282, 17'd36399, 17'd14634, 17'd28770,
        17'd45862, 17'd28672, 17'd46845, 17'd27768
    };

    // stage advance strobes shared by the channel datapaths
    typedef struct packed {
        logic prod_load;
        logic out_load;
    } cxcds_adv_t;

    function automatic logic signed [DIFF_W-1:0] sample_ext(input logic [IN_W-1:0] raw);
        logic signed [SAMPLE_BITS-1:0] s;
        s = raw[SAMPLE_BITS-1:0];
        return DIFF_W'(s);
    endfunction

endpackage

`default_nettype wire

// ----- sv/cxcds_chan.sv -----
// cxcds_chan: one corrected channel, product stage then sum and round stage
// depends on cxcds_pkg
`default_nettype none

module cxcds_chan (
    input  wire logic                                 aclk,
    input  wire cxcds_pkg::cxcds_adv_t                adv,
    input  wire logic signed [cxcds_pkg::DIFF_W-1:0] own,
    input  wire logic signed [cxcds_pkg::DIFF_W-1:0] x1,
    input  wire logic signed [cxcds_pkg::DIFF_W-1:0] x2,
    input  wire logic        [cxcds_pkg::GAIN_W-1:0] g1,
    input  wire logic        [cxcds_pkg::GAIN_W-1:0] g2,
    output logic signed      [cxcds_pkg::CORR_W-1:0] corrected
);

    logic signed [cxcds_pkg::GAIN_W:0]   g1_s;
    logic signed [cxcds_pkg::GAIN_W:0]   g2_s;
    logic signed [cxcds_pkg::PROD_W-1:0] prod1_next, prod1_reg;
    logic signed [cxcds_pkg::PROD_W-1:0] prod2_next, prod2_reg;
    logic signed [cxcds_pkg::ACC_W-1:0]  own_next, own_reg;
    logic signed [cxcds_pkg::ACC_W-1:0]  acc;
    logic signed [cxcds_pkg::Q8_W-1:0]   q8;
    logic signed [cxcds_pkg::CORR_W-1:0] corr_next, corr_reg;

    assign g1_s = {1'b0, g1};
    assign g2_s = {1'b0, g2};

    // own term in q.16 with the rounding half already in its empty low bits
    assign own_next   = (cxcds_pkg::ACC_W'(own) <<< cxcds_pkg::FRAC_IN)
                      | cxcds_pkg::ACC_W'(cxcds_pkg::ROUND_HALF);
    assign prod1_next = cxcds_pkg::PROD_W'(x1) * cxcds_pkg::PROD_W'(g1_s);
    assign prod2_next = cxcds_pkg::PROD_W'(x2) * cxcds_pkg::PROD_W'(g2_s);

    always_ff @(posedge aclk) begin
        if (adv.prod_load) begin
            own_reg   <= own_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
    end

    assign acc = own_reg - cxcds_pkg::ACC_W'(prod1_reg) - cxcds_pkg::ACC_W'(prod2_reg);
    assign q8  = acc[cxcds_pkg::ACC_W-1:cxcds_pkg::ROUND_SHIFT];
    assign corr_next = cxcds_pkg::CORR_W'(q8);

    always_ff @(posedge aclk) begin
        if (adv.out_load) begin
            corr_reg <= corr_next;
        end
    end

    assign corrected = corr_reg;

endmodule

`default_nettype wire

// ----- sv/crosstalk_corrected_cds.sv -----
// crosstalk_corrected_cds: top level, handshake pipeline, gain registers
// depends on cxcds_pkg and cxcds_chan
`default_nettype none

// pipeline stages, in order: difference, multiply, sum/round
// throughput: one word per cycle unless the output stalls; each stage advances on its own, so bubbles close up
// a finished word held at the output stalls the earlier stages once they are full
// reset: synchronous, active low; clears all stage valids and loads the default gains
// gain writes take effect on the next clock edge, no read-back

module crosstalk_corrected_cds (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    // configuration write port
    input  wire logic                                   cfg_wen,
    input  wire logic        [cxcds_pkg::GIDX_W-1:0]   cfg_index,
    input  wire logic        [cxcds_pkg::GAIN_W-1:0]   cfg_wdata,

    // input word
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_a_first,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_a_second,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_a_third,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_b_first,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_b_second,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_b_third,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_c_first,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_c_second,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_c_third,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_d_first,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_d_second,
    input  wire logic signed [cxcds_pkg::IN_W-1:0]     s_d_third,

    // result word
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [cxcds_pkg::CORR_W-1:0]   m_a_corrected,
    output logic signed      [cxcds_pkg::CORR_W-1:0]   m_b_corrected,
    output logic signed      [cxcds_pkg::CORR_W-1:0]   m_c_corrected,
    output logic signed      [cxcds_pkg::CORR_W-1:0]   m_d_corrected,
    output logic signed      [cxcds_pkg::PLAIN_W-1:0]  m_a_plain,
    output logic signed      [cxcds_pkg::PLAIN_W-1:0]  m_b_plain,
    output logic signed      [cxcds_pkg::PLAIN_W-1:0]  m_c_plain,
    output logic signed      [cxcds_pkg::PLAIN_W-1:0]  m_d_plain
);

    // ---------------------------------------------------------------
    // gain registers
    // ---------------------------------------------------------------
    logic [cxcds_pkg::NUM_GAINS-1:0][cxcds_pkg::GAIN_W-1:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= cxcds_pkg::GAIN_RESET;
        end else if (cfg_wen) begin
            gain_reg[cfg_index] <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // stage control: a stage may load when it is empty or its word moves on
    // ---------------------------------------------------------------
    logic diff_valid_reg, prod_valid_reg, out_valid_reg;
    logic diff_ready, prod_ready, out_ready;
    cxcds_pkg::cxcds_adv_t adv;

    assign out_ready  = !out_valid_reg  || m_ready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign diff_ready = !diff_valid_reg || prod_ready;

    assign adv = '{prod_load: prod_ready, out_load: out_ready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (diff_ready) begin
                diff_valid_reg <= s_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= diff_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    assign s_ready = diff_ready;
    assign m_valid = out_valid_reg;

    // ---------------------------------------------------------------
    // difference stage: sign-extended samples, the own and cross-term differences
    // ---------------------------------------------------------------
    logic signed [cxcds_pkg::DIFF_W-1:0] a0, a1, a2, b0, b1, b2;
    logic signed [cxcds_pkg::DIFF_W-1:0] c0, c1, c2, d0, d1, d2;

    assign a0 = cxcds_pkg::sample_ext(s_a_first);
    assign a1 = cxcds_pkg::sample_ext(s_a_second);
    assign a2 = cxcds_pkg::sample_ext(s_a_third);
    assign b0 = cxcds_pkg::sample_ext(s_b_first);
    assign b1 = cxcds_pkg::sample_ext(s_b_second);
    assign b2 = cxcds_pkg::sample_ext(s_b_third);
    assign c0 = cxcds_pkg::sample_ext(s_c_first);
    assign c1 = cxcds_pkg::sample_ext(s_c_second);
    assign c2 = cxcds_pkg::sample_ext(s_c_third);
    assign d0 = cxcds_pkg::sample_ext(s_d_first);
    assign d1 = cxcds_pkg::sample_ext(s_d_second);
    assign d2 = cxcds_pkg::sample_ext(s_d_third);

    // pedestal minus signal per channel, plus the cross terms of the other pair
    logic signed [cxcds_pkg::DIFF_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [cxcds_pkg::DIFF_W-1:0] c01_reg, d01_reg, a12_reg, b12_reg;

    always_ff @(posedge aclk) begin
        if (diff_ready) begin
            pa_reg  <= a0 - a1;
            pb_reg  <= b0 - b1;
            pc_reg  <= c1 - c2;
            pd_reg  <= d1 - d2;
            c01_reg <= c0 - c1;
            d01_reg <= d0 - d1;
            a12_reg <= a1 - a2;
            b12_reg <= b1 - b2;
        end
    end

    // plain differences ride alongside the corrected datapath
    logic signed [cxcds_pkg::DIFF_W-1:0] pa_prod_reg, pb_prod_reg, pc_prod_reg, pd_prod_reg;
    logic signed [cxcds_pkg::DIFF_W-1:0] pa_out_reg, pb_out_reg, pc_out_reg, pd_out_reg;

    always_ff @(posedge aclk) begin
        if (prod_ready) begin
            pa_prod_reg <= pa_reg;
            pb_prod_reg <= pb_reg;
            pc_prod_reg <= pc_reg;
            pd_prod_reg <= pd_reg;
        end
        if (out_ready) begin
            pa_out_reg <= pa_prod_reg;
            pb_out_reg <= pb_prod_reg;
            pc_out_reg <= pc_prod_reg;
            pd_out_reg <= pd_prod_reg;
        end
    end

    assign m_a_plain = cxcds_pkg::PLAIN_W'(pa_out_reg);
    assign m_b_plain = cxcds_pkg::PLAIN_W'(pb_out_reg);
    assign m_c_plain = cxcds_pkg::PLAIN_W'(pc_out_reg);
    assign m_d_plain = cxcds_pkg::PLAIN_W'(pd_out_reg);

    // ---------------------------------------------------------------
    // corrected channels: channels 0/1 lose weighted 2/3 and vice versa
    // ---------------------------------------------------------------
    cxcds_chan u_chan_a (
        .aclk      (aclk),
        .adv       (adv),
        .own       (pa_reg),
        .x1        (c01_reg),
        .x2        (d01_reg),
        .g1        (gain_reg[cxcds_pkg::GAIN_A_FROM_C]),
        .g2        (gain_reg[cxcds_pkg::GAIN_A_FROM_D]),
        .corrected (m_a_corrected)
    );

    cxcds_chan u_chan_b (
        .aclk      (aclk),
        .adv       (adv),
        .own       (pb_reg),
        .x1        (c01_reg),
        .x2        (d01_reg),
        .g1        (gain_reg[cxcds_pkg::GAIN_B_FROM_C]),
        .g2        (gain_reg[cxcds_pkg::GAIN_B_FROM_D]),
        .corrected (m_b_corrected)
    );

    cxcds_chan u_chan_c (
        .aclk      (aclk),
        .adv       (adv),
        .own       (pc_reg),
        .x1        (a12_reg),
        .x2        (b12_reg),
        .g1        (gain_reg[cxcds_pkg::GAIN_C_FROM_A]),
        .g2        (gain_reg[cxcds_pkg::GAIN_C_FROM_B]),
        .corrected (m_c_corrected)
    );

    cxcds_chan u_chan_d (
        .aclk      (aclk),
        .adv       (adv),
        .own       (pd_reg),
        .x1        (a12_reg),
        .x2        (b12_reg),
        .g1        (gain_reg[cxcds_pkg::GAIN_D_FROM_A]),
        .g2        (gain_reg[cxcds_pkg::GAIN_D_FROM_B]),
        .corrected (m_d_corrected)
    );

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // input only stalls when every stage is holding a word
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (diff_valid_reg && prod_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

    // an accepted word always lands in the difference stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> diff_valid_reg)
        else $error("accepted word lost at the difference stage");

    // a word in the product stage moves to the output when the output can take it
    a_prod_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_valid_reg && out_ready) |=> out_valid_reg)
        else $error("word lost between product and output stage");

    // plain difference carried unchanged into the product stage
    a_plain_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (diff_valid_reg && prod_ready) |=> (pa_prod_reg == $past(pa_reg)))
        else $error("plain difference corrupted in the pipeline");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for crosstalk_corrected_cds, directed table then random words
// depends on cxcds_pkg (widths, gain index enum) and the crosstalk_corrected_cds rtl

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cxcds_pkg::*;

    // ------------------------------------------------------------------
    // bench constants
    // ------------------------------------------------------------------
    localparam int RESET_CYCLES    = 5;
    localparam int PIPE_LATENCY    = 3;      // difference, multiply, sum/round
    localparam int TAIL_CYCLES     = PIPE_LATENCY + 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int SQUEEZE_PHASE   = 2;      // phase in which the receiver holds off
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;   // well above the hold-off plus any gap

    // one pixel group: channel a..d, sample 0..2
    typedef logic [0:2][IN_W-1:0] sample_trio_t;
    typedef logic [0:3][0:2][IN_W-1:0] pixel_t;

    typedef struct packed {
        logic [0:3][CORR_W-1:0]  corr;   // a..d corrected, 8 fraction bits
        logic [0:3][PLAIN_W-1:0] plain;  // a..d plain differences
    } cds_result_t;

    typedef logic [0:NUM_GAINS-1][GAIN_W-1:0] gain_set_t;

    typedef struct packed {
        pixel_t      px;
        logic        known;  // result typed in below rather than predicted
        cds_result_t res;
    } dir_row_t;

    localparam logic [IN_W-1:0] S_MAX  = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] S_MIN  = 32'h8000_0000;
    localparam logic [IN_W-1:0] S_NEG1 = 32'hFFFF_FFFF;
    localparam logic [IN_W-1:0] S_ONE  = 32'd1;

    // gains after reset, register 0 first
    localparam gain_set_t RESET_GAINS = '{
        17'd27768, 17'd46845, 17'd28672, 17'd45862,
        17'd28770, 17'd14634, 17'd36399, 17'd17282
    };
    // half an lsb of q.8 per unit difference, so single steps land on rounding ties
    localparam gain_set_t TIE_GAINS = {NUM_GAINS{17'd128}};

    // full-scale difference: max minus min
    localparam logic signed [CORR_W-1:0]  FULL_CORR  = 44'sd1099511627520;
    localparam logic signed [PLAIN_W-1:0] FULL_PLAIN = 33'sd4294967295;

    localparam sample_trio_t TRIO_Z       = '0;
    localparam sample_trio_t TRIO_FLAT    = '{32'd12345, 32'd12345, 32'd12345};
    localparam sample_trio_t TRIO_MAX     = '{S_MAX, S_MAX, S_MAX};
    localparam sample_trio_t TRIO_MIN     = '{S_MIN, S_MIN, S_MIN};
    localparam sample_trio_t TRIO_UP      = '{S_MAX, S_MIN, S_MIN};  // early pair, +full
    localparam sample_trio_t TRIO_DN      = '{S_MIN, S_MAX, S_MAX};  // early pair, -full
    localparam sample_trio_t TRIO_LATE_UP = '{S_MAX, S_MAX, S_MIN};  // late pair, +full
    localparam sample_trio_t TRIO_LATE_DN = '{S_MIN, S_MIN, S_MAX};  // late pair, -full
    localparam sample_trio_t TRIO_ZIG     = '{S_MAX, S_MIN, S_MAX};
    localparam sample_trio_t TRIO_ZAG     = '{S_MIN, S_MAX, S_MIN};
    localparam sample_trio_t TRIO_ALT_A   = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
    localparam sample_trio_t TRIO_ALT_5   = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    localparam sample_trio_t TRIO_NEG     = '{S_NEG1, 32'd0, S_NEG1};

    // ------------------------------------------------------------------
    // directed table: rows before TIE_FIRST run on the reset gains,
    // the rest with every gain at 128 to land exactly on rounding ties
    // ------------------------------------------------------------------
    localparam int DIR_ROW_COUNT = 23;
    localparam int TIE_FIRST     = 19;

    localparam dir_row_t DIR_ROWS [0:DIR_ROW_COUNT-1] = '{
        // all zero
        '{px: '{TRIO_Z, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b1, res: '0},
        // one lsb of pedestal on channel a only
        '{px: '{'{S_ONE, 32'd0, 32'd0}, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b1,
          res: '{corr: '{44'sd256, 44'sd0, 44'sd0, 44'sd0},
                 plain: '{33'sd1, 33'sd0, 33'sd0, 33'sd0}}},
        // flat samples cancel everywhere
        '{px: '{TRIO_FLAT, TRIO_FLAT, TRIO_FLAT, TRIO_FLAT}, known: 1'b1, res: '0},
        '{px: '{TRIO_MAX, TRIO_MAX, TRIO_MAX, TRIO_MAX}, known: 1'b1, res: '0},
        '{px: '{TRIO_MIN, TRIO_MIN, TRIO_MIN, TRIO_MIN}, known: 1'b1, res: '0},
        // full-scale swing on one channel, no crosstalk source moves
        '{px: '{TRIO_UP, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b1,
          res: '{corr: '{FULL_CORR, 44'sd0, 44'sd0, 44'sd0},
                 plain: '{FULL_PLAIN, 33'sd0, 33'sd0, 33'sd0}}},
        '{px: '{TRIO_DN, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b1,
          res: '{corr: '{-FULL_CORR, 44'sd0, 44'sd0, 44'sd0},
                 plain: '{-FULL_PLAIN, 33'sd0, 33'sd0, 33'sd0}}},
        '{px: '{TRIO_Z, TRIO_UP, TRIO_Z, TRIO_Z}, known: 1'b1,
          res: '{corr: '{44'sd0, FULL_CORR, 44'sd0, 44'sd0},
                 plain: '{33'sd0, FULL_PLAIN, 33'sd0, 33'sd0}}},
        '{px: '{TRIO_Z, TRIO_Z, TRIO_LATE_UP, TRIO_Z}, known: 1'b1,
          res: '{corr: '{44'sd0, 44'sd0, FULL_CORR, 44'sd0},
                 plain: '{33'sd0, 33'sd0, FULL_PLAIN, 33'sd0}}},
        '{px: '{TRIO_Z, TRIO_Z, TRIO_Z, TRIO_LATE_DN}, known: 1'b1,
          res: '{corr: '{44'sd0, 44'sd0, 44'sd0, -FULL_CORR},
                 plain: '{33'sd0, 33'sd0, 33'sd0, -FULL_PLAIN}}},
        // all four at full scale together, sources still quiet
        '{px: '{TRIO_UP, TRIO_DN, TRIO_LATE_UP, TRIO_LATE_DN}, known: 1'b1,
          res: '{corr: '{FULL_CORR, -FULL_CORR, FULL_CORR, -FULL_CORR},
                 plain: '{FULL_PLAIN, -FULL_PLAIN, FULL_PLAIN, -FULL_PLAIN}}},
        // crosstalk sources alone, left to the predictor
        '{px: '{TRIO_Z, TRIO_Z, '{S_ONE, 32'd0, 32'd0}, TRIO_Z}, known: 1'b0, res: '0},
        '{px: '{TRIO_Z, TRIO_Z, TRIO_Z, '{S_MAX, 32'd0, 32'd0}}, known: 1'b0, res: '0},
        '{px: '{'{32'd0, 32'd0, S_MIN}, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b0, res: '0},
        '{px: '{TRIO_Z, '{32'd0, 32'd0, S_MAX}, TRIO_Z, TRIO_Z}, known: 1'b0, res: '0},
        // large swings on every term, then single-lsb swings on every term
        '{px: '{TRIO_ZIG, TRIO_ZIG, TRIO_ZIG, TRIO_ZIG}, known: 1'b0, res: '0},
        '{px: '{TRIO_ZAG, TRIO_ZAG, TRIO_ZAG, TRIO_ZAG}, known: 1'b0, res: '0},
        '{px: '{TRIO_ALT_A, TRIO_ALT_5, TRIO_ALT_A, TRIO_ALT_5}, known: 1'b0, res: '0},
        '{px: '{TRIO_NEG, TRIO_NEG, TRIO_NEG, TRIO_NEG}, known: 1'b0, res: '0},
        // ties, gains all 128: -0.5 rounds up to 0, +0.5 rounds up to 1
        '{px: '{TRIO_Z, TRIO_Z, '{S_ONE, 32'd0, 32'd0}, TRIO_Z}, known: 1'b1, res: '0},
        '{px: '{TRIO_Z, TRIO_Z, '{S_NEG1, 32'd0, 32'd0}, TRIO_Z}, known: 1'b1,
          res: '{corr: '{44'sd1, 44'sd1, 44'sd0, 44'sd0}, plain: '0}},
        '{px: '{'{32'd0, 32'd0, S_ONE}, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b1,
          res: '{corr: '{44'sd0, 44'sd0, 44'sd1, 44'sd1}, plain: '0}},
        '{px: '{'{32'd0, 32'd0, S_NEG1}, TRIO_Z, TRIO_Z, TRIO_Z}, known: 1'b1, res: '0}
    };

    // ------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wen   = 1'b0;
    logic [GIDX_W-1:0]   cfg_index = '0;
    logic [GAIN_W-1:0]   cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                m_ready   = 1'b0;
    pixel_t              s_word    = '0;
    logic                s_has_res = 1'b0;  // word carries a typed-in result
    cds_result_t         s_res     = '0;

    logic                s_ready;
    logic                m_valid;
    logic signed [CORR_W-1:0]  m_a_corrected, m_b_corrected, m_c_corrected, m_d_corrected;
    logic signed [PLAIN_W-1:0] m_a_plain, m_b_plain, m_c_plain, m_d_plain;

    gain_set_t   gain_model = RESET_GAINS;  // bench copy of the gain registers
    cds_result_t pending_cds [$];           // results still owed by the block
    int          fail_count   = 0;
    int          stall_cycles = 0;
    int          burst_left   = 0;
    bit          hold_off_req = 1'b0;       // receiver to hold off, sender to stay busy

    string corr_names [0:3]  = '{"a_corrected", "b_corrected", "c_corrected", "d_corrected"};
    string plain_names [0:3] = '{"a_plain", "b_plain", "c_plain", "d_plain"};

    always #5 aclk = ~aclk;

    crosstalk_corrected_cds dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_first     (s_word[0][0]),
        .s_a_second    (s_word[0][1]),
        .s_a_third     (s_word[0][2]),
        .s_b_first     (s_word[1][0]),
        .s_b_second    (s_word[1][1]),
        .s_b_third     (s_word[1][2]),
        .s_c_first     (s_word[2][0]),
        .s_c_second    (s_word[2][1]),
        .s_c_third     (s_word[2][2]),
        .s_d_first     (s_word[3][0]),
        .s_d_second    (s_word[3][1]),
        .s_d_third     (s_word[3][2]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_a_corrected (m_a_corrected),
        .m_b_corrected (m_b_corrected),
        .m_c_corrected (m_c_corrected),
        .m_d_corrected (m_d_corrected),
        .m_a_plain     (m_a_plain),
        .m_b_plain     (m_b_plain),
        .m_c_plain     (m_c_plain),
        .m_d_plain     (m_d_plain)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // own difference in q.16 less two gain-weighted source differences,
    // then round half up to q.8 by an arithmetic shift
    function automatic longint corrected_q8(input longint own, input longint src1,
                                            input longint src2,
                                            input logic [GAIN_W-1:0] g1,
                                            input logic [GAIN_W-1:0] g2);
        longint q16;
        q16 = own * 64'sd65536 - longint'(g1) * src1 - longint'(g2) * src2;
        return (q16 + 64'sd128) >>> 8;
    endfunction

    function automatic cds_result_t cds_of(input pixel_t px);
        longint      smp [0:3][0:2];
        longint      own [0:3];
        longint      c01, d01, a12, b12;
        cds_result_t r;
        for (int ch = 0; ch < 4; ch++) begin
            for (int k = 0; k < 3; k++) begin
                smp[ch][k] = longint'($signed(px[ch][k]));
            end
        end
        // a and b: sample 0 pedestal, sample 1 signal; c and d one sample later
        own[0] = smp[0][0] - smp[0][1];
        own[1] = smp[1][0] - smp[1][1];
        own[2] = smp[2][1] - smp[2][2];
        own[3] = smp[3][1] - smp[3][2];
        // sources seen at the same sample positions in the other pair
        c01 = smp[2][0] - smp[2][1];
        d01 = smp[3][0] - smp[3][1];
        a12 = smp[0][1] - smp[0][2];
        b12 = smp[1][1] - smp[1][2];
        r.corr[0] = 44'(corrected_q8(own[0], c01, d01,
                        gain_model[GAIN_A_FROM_C], gain_model[GAIN_A_FROM_D]));
        r.corr[1] = 44'(corrected_q8(own[1], c01, d01,
                        gain_model[GAIN_B_FROM_C], gain_model[GAIN_B_FROM_D]));
        r.corr[2] = 44'(corrected_q8(own[2], a12, b12,
                        gain_model[GAIN_C_FROM_A], gain_model[GAIN_C_FROM_B]));
        r.corr[3] = 44'(corrected_q8(own[3], a12, b12,
                        gain_model[GAIN_D_FROM_A], gain_model[GAIN_D_FROM_B]));
        for (int i = 0; i < 4; i++) begin
            r.plain[i] = 33'(own[i]);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [IN_W-1:0] extreme_sample();
        case ($urandom_range(0, 3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return S_NEG1;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0, 1:    return extreme_sample();
            2:       return 32'($urandom_range(0, 511)) - 32'd256;
            default: return $urandom;
        endcase
    endfunction

    // mix of fully random, realistic (small swings about a level), small and extreme groups
    function automatic pixel_t random_pixel();
        pixel_t          px;
        logic [IN_W-1:0] level;
        int              kind;
        level = '0;
        kind  = $urandom_range(0, 3);
        for (int ch = 0; ch < 4; ch++) begin
            for (int k = 0; k < 3; k++) begin
                case (kind)
                    0: px[ch][k] = rand_sample();
                    1: begin
                        if (k == 0) level = $urandom;
                        px[ch][k] = level + 32'($urandom_range(0, 2047)) - 32'd1024;
                    end
                    2: px[ch][k] = 32'($urandom_range(0, 511)) - 32'd256;
                    default: px[ch][k] = extreme_sample();
                endcase
            end
        end
        return px;
    endfunction

    function automatic gain_set_t gain_setting(input int phase);
        gain_set_t g;
        for (int i = 0; i < NUM_GAINS; i++) begin
            case (phase)
                0: g[i] = '0;
                1: g[i] = '1;
                3: begin
                    // each gain at an extreme or anywhere
                    case ($urandom_range(0, 2))
                        0:       g[i] = '0;
                        1:       g[i] = '1;
                        default: g[i] = GAIN_W'($urandom);
                    endcase
                end
                4: g[i] = RESET_GAINS[i];
                5: g[i] = (i % 2) ? 17'h0AAAA : 17'h15555;
                7: g[i] = 17'd1;
                default: g[i] = GAIN_W'($urandom);
            endcase
        end
        return g;
    endfunction

    // back-to-back writes of all eight gains; only called with the block idle
    task automatic load_gains(input gain_set_t g);
        for (int i = 0; i < NUM_GAINS; i++) begin
            cfg_wen   <= 1'b1;
            cfg_index <= GIDX_W'(i);
            cfg_wdata <= g[i];
            @(posedge aclk);
        end
        cfg_wen    <= 1'b0;
        gain_model  = g;
    endtask

    // offer one word, hold it until taken, then maybe drop valid for a gap
    task automatic send_word(input pixel_t px, input logic known, input cds_result_t res);
        int gap;
        s_word    <= px;
        s_has_res <= known;
        s_res     <= res;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(20, 40);
                default:    gap = $urandom_range(1, 12);
            endcase
            // keep pushing while the receiver is held off
            if (hold_off_req) gap = 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // sender pause: wait until every owed result is out, then let the pipe settle
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cds.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset gains first, then the rounding ties
        for (int r = 0; r < DIR_ROW_COUNT; r++) begin
            if (r == TIE_FIRST) begin
                drain_results();
                load_gains(TIE_GAINS);
            end
            send_word(DIR_ROWS[r].px, DIR_ROWS[r].known, DIR_ROWS[r].res);
        end

        // random words under a new gain setting per phase
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            load_gains(gain_setting(phase));
            if (phase == SQUEEZE_PHASE) hold_off_req = 1'b1;
            repeat (ITEMS_PER_PHASE) send_word(random_pixel(), 1'b0, '0);
        end

        drain_results();
        if (fail_count == 0) begin
            $display("** crosstalk_corrected_cds: PASSED **");
        end else begin
            $display("** crosstalk_corrected_cds: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: segments of random length, each with its own stall pattern,
    // plus one long hold-off so the pipe fills and s_ready drops
    // ------------------------------------------------------------------
    initial begin
        int seg_len;
        int pattern;
        forever begin
            seg_len = $urandom_range(20, 200);
            pattern = $urandom_range(0, 3);
            for (int k = 0; k < seg_len; k++) begin
                @(posedge aclk);
                if (hold_off_req) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                    hold_off_req = 1'b0;
                end
                case (pattern)
                    0:       m_ready <= 1'b1;                       // no stalls
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
                    default: m_ready <= (k % 4 != 3);              // one stall in four
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // scoreboard: queue prediction on input acceptance, compare on output
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cds_result_t got;
        cds_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_cds.insert(pending_cds.size(), s_has_res ? s_res : cds_of(s_word));
            end
            if (m_valid && m_ready) begin
                got.corr  = {m_a_corrected, m_b_corrected, m_c_corrected, m_d_corrected};
                got.plain = {m_a_plain, m_b_plain, m_c_plain, m_d_plain};
                if (pending_cds.size() == 0) begin
                    $error("result word with none expected");
                    fail_count++;
                end else begin
                    want = pending_cds.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got.corr[i] !== want.corr[i]) begin
                            $error("%s: expected %0d, got %0d", corr_names[i],
                                   $signed(want.corr[i]), $signed(got.corr[i]));
                            fail_count++;
                        end
                        if (got.plain[i] !== want.plain[i]) begin
                            $error("%s: expected %0d, got %0d", plain_names[i],
                                   $signed(want.plain[i]), $signed(got.plain[i]));
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** crosstalk_corrected_cds: FAILED **");
            $finish;
        end
    end

endmodule
